[sv/drpr_pkg.sv]
// Shared types and constants of the diagnostic response packet receiver.
package drpr_pkg;

   // Header bytes of a response packet.
   localparam logic [7:0] HDR0 = 8'h80;
   localparam logic [7:0] HDR1 = 8'hF0;
   localparam logic [7:0] HDR2 = 8'h10;

   // Packet positions of the fixed fields.
   localparam logic [8:0] POS_HDR1  = 9'd1;
   localparam logic [8:0] POS_HDR2  = 9'd2;
   localparam logic [8:0] POS_LEN   = 9'd3;
   localparam logic [8:0] POS_SPARE = 9'd4;
   localparam logic [8:0] POS_DATA0 = 9'd5;
   localparam logic [8:0] POS_HUNT  = 9'd0;

   // Request kinds.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Response kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   // Register map.
   localparam int         CSR_INDEX_W       = 2;
   localparam int         CSR_DATA_W        = 16;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_BUFFER_SIZE   = 2'd1;
   localparam logic [1:0] CSR_COMPACT_MODE  = 2'd2;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;
   localparam logic [7:0]  BUFFER_SIZE_RESET   = 8'd255;
   localparam logic        COMPACT_MODE_RESET  = 1'b0;

   // Packed response data width (27 bits of fields, padded to bytes).
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic       kind;
      logic [7:0] slot;
      logic [7:0] data_value;
      logic [8:0] packet_pos;
      logic [1:0] status;
   } drpr_result_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  buffer_size;
      logic        compact_mode;
   } drpr_cfg_type;

endpackage

[sv/diag_response_packet_receiver.sv]
// Top level of the diagnostic response packet receiver.
//
// The receiver takes one request per cycle: either a received serial byte
// (req_tuser = 0, byte in req_tdata) or one elapsed timer tick (req_tuser = 1).
// It hunts for the header 0x80 0xF0 0x10, then takes a length byte, one
// unused byte, the data bytes and a trailing 8-bit sum checksum. Each data
// byte can produce a buffer write response (rsp_tuser = 0); the checksum byte
// or a receive timeout produces a status response (rsp_tuser = 1), after
// which the receiver re-arms and hunts for a new header. A header byte that
// does not match is dropped and the receiver keeps waiting for the expected
// byte. Every byte clears the idle tick count; a tick that pushes the count
// past timeout_ticks reports a timeout, also while hunting. In plain mode data
// byte p is written to slot p-5 when that slot is below buffer_size; in
// compact mode only non-zero bytes are kept, packed from slot 0, up to half
// of buffer_size, each carrying its packet position. Every request is
// handled in the cycle in which it is accepted, so one request per
// clock is sustained; the response sits in an output register with one
// skid entry behind it, and req_tready drops only while that skid entry is
// occupied by a response the consumer has not yet taken. A response is
// registered before it shows on rsp_tvalid. Configuration writes are
// always accepted (csr_ready is high) and registered; indexes beyond
// the register list are ignored.
module diag_response_packet_receiver #(
   parameter logic [15:0] TIMEOUT_RESET = drpr_pkg::TIMEOUT_TICKS_RESET,
   parameter logic [7:0]  BUFSIZE_RESET = drpr_pkg::BUFFER_SIZE_RESET,
   parameter logic        COMPACT_RESET = drpr_pkg::COMPACT_MODE_RESET
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] rx_byte
   input  logic                                req_tuser,  // [0] cmd
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] slot, [15:8] data_value, [24:16] packet_pos, [26:25] status,
   // [31:27] zero
   output logic [drpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // [0] kind
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [drpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   drpr_pkg::drpr_cfg_type    cfg_ff;
   drpr_pkg::drpr_result_type parse_res;
   drpr_pkg::drpr_result_type out_res;
   logic                      parse_valid;
   logic                      req_accept;
   logic                      can_push;

   // The only backpressure source is a full skid entry.
   assign req_tready = can_push;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.buffer_size   <= BUFSIZE_RESET;
         cfg_ff.compact_mode  <= COMPACT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            drpr_pkg::CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            drpr_pkg::CSR_BUFFER_SIZE:   cfg_ff.buffer_size   <= csr_wdata[7:0];
            drpr_pkg::CSR_COMPACT_MODE:  cfg_ff.compact_mode  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Packet state and the per-request decision.
   drpr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .cmd       (req_tuser),
      .rx_byte   (req_tdata),
      .cfg       (cfg_ff),
      .res_valid (parse_valid),
      .res       (parse_res)
   );

   // Response register with skid entry.
   drpr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && parse_valid),
      .push_data (parse_res),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tuser = out_res.kind;
   assign rsp_tdata = {5'd0, out_res.status, out_res.packet_pos,
                       out_res.data_value, out_res.slot};

endmodule

[sv/drpr_parse.sv]
// Packet parser: tracks position, length, checksum, kept count and idle ticks per request.
module drpr_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     cmd,
   input  logic [7:0]               rx_byte,
   input  drpr_pkg::drpr_cfg_type   cfg,
   output logic                     res_valid,
   output drpr_pkg::drpr_result_type res
);

   logic [8:0]  position_ff,   position_in;
   logic [7:0]  length_ff,     length_in;
   logic [7:0]  sum_ff,        sum_in;
   logic [7:0]  kept_ff,       kept_in;
   logic [16:0] idle_ff,       idle_in;

   logic [8:0]  pkt_end;
   logic [16:0] idle_next;
   logic [8:0]  plain_slot;
   logic [7:0]  sum_add;
   logic        hdr_match;
   logic        rearm;

   assign pkt_end    = {1'b0, length_ff} + drpr_pkg::POS_SPARE;
   assign idle_next  = idle_ff + 17'd1;
   assign plain_slot = position_ff - drpr_pkg::POS_DATA0;
   assign sum_add    = sum_ff + rx_byte;
   assign hdr_match  = (position_ff == drpr_pkg::POS_HUNT && rx_byte == drpr_pkg::HDR0) ||
                       (position_ff == drpr_pkg::POS_HDR1 && rx_byte == drpr_pkg::HDR1) ||
                       (position_ff == drpr_pkg::POS_HDR2 && rx_byte == drpr_pkg::HDR2);

   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      kept_in     = kept_ff;
      idle_in     = idle_ff;
      rearm       = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      if (cmd == drpr_pkg::CMD_TICK) begin
         idle_in = idle_next;
         if (idle_next > {1'b0, cfg.timeout_ticks}) begin
            res_valid  = 1'b1;
            res.kind   = drpr_pkg::KIND_STATUS;
            res.status = drpr_pkg::STATUS_TIMEOUT;
            rearm      = 1'b1;
         end
      end else begin
         idle_in = '0;
         if (hdr_match || position_ff == drpr_pkg::POS_LEN ||
             position_ff == drpr_pkg::POS_SPARE) begin
            if (position_ff == drpr_pkg::POS_LEN) begin
               length_in = rx_byte;
            end
            sum_in      = sum_add;
            position_in = position_ff + 9'd1;
         end else if (position_ff > drpr_pkg::POS_SPARE && position_ff < pkt_end) begin
            if (!cfg.compact_mode) begin
               if (plain_slot < {1'b0, cfg.buffer_size}) begin
                  res_valid      = 1'b1;
                  res.kind       = drpr_pkg::KIND_DATA;
                  res.slot       = plain_slot[7:0];
                  res.data_value = rx_byte;
                  res.packet_pos = position_ff;
               end
            end else if (kept_ff < (cfg.buffer_size >> 1) && rx_byte != 8'd0) begin
               res_valid      = 1'b1;
               res.kind       = drpr_pkg::KIND_DATA;
               res.slot       = kept_ff;
               res.data_value = rx_byte;
               res.packet_pos = position_ff;
               kept_in        = kept_ff + 8'd1;
            end
            sum_in      = sum_add;
            position_in = position_ff + 9'd1;
         end else if (position_ff == pkt_end && position_ff > drpr_pkg::POS_SPARE) begin
            res_valid  = 1'b1;
            res.kind   = drpr_pkg::KIND_STATUS;
            res.status = (rx_byte == sum_ff) ? drpr_pkg::STATUS_OK
                                              : drpr_pkg::STATUS_BAD_SUM;
            rearm      = 1'b1;
         end
      end
      if (rearm) begin
         position_in = '0;
         length_in   = '0;
         sum_in      = '0;
         kept_in     = '0;
         idle_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         kept_ff     <= '0;
         idle_ff     <= '0;
      end else if (accept) begin
         position_ff <= position_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         kept_ff     <= kept_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

[sv/drpr_out_buf.sv]
// Two-entry response buffer: output register plus a skid register.
module drpr_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  drpr_pkg::drpr_result_type push_data,
   output logic                      can_push,
   output logic                      out_valid,
   input  logic                      out_ready,
   output drpr_pkg::drpr_result_type out_data
);

   logic                      main_valid_ff, main_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   drpr_pkg::drpr_result_type main_ff,       main_in;
   drpr_pkg::drpr_result_type skid_ff,       skid_in;
   logic                      pop;

   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

[sv/drpr_checker.sv]
// Port-level checker for the diagnostic response packet receiver, with its bind.
module drpr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [drpr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A status report carries only a legal status and zero in bits 24:0.
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == drpr_pkg::KIND_STATUS |->
         rsp_tdata[24:0] == 25'd0 && rsp_tdata[26:25] != 2'd3)
      else $error("malformed status report");

   // A data write comes from a data position and carries status ok.
   a_data_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == drpr_pkg::KIND_DATA |->
         rsp_tdata[26:25] == drpr_pkg::STATUS_OK &&
         rsp_tdata[24:16] >= drpr_pkg::POS_DATA0 && rsp_tdata[31:27] == 5'd0)
      else $error("malformed data write");

   // Nothing is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind diag_response_packet_receiver drpr_checker u_drpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
